[rtl/aes128_pkg.sv]
// Package for the AES-128 block cipher: payload structs, state codes,
// S-box functions and byte-level helpers. No dependencies.
package aes128_pkg;

  localparam int CfgIdxW = 1;

  localparam logic [CfgIdxW-1:0] REG_KEY_HIGH = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_KEY_LOW  = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [63:0] block_high;
    logic [63:0] block_low;
  } aes_in_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } aes_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_LOAD,
    ST_ROUND,
    ST_DONE
  } aes_state_t;

  function automatic logic [7:0] fwd_sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return t[x];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
    return t[x];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // state byte k sits at bits [127-8k -: 8]
  function automatic logic [127:0] sub_shift(input logic [127:0] s, input logic inv);
    logic [127:0] o;
    int m;
    o = '0;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        m = r + 4 * ((c + r) % 4);
        if (inv) begin
          o[127-8*m -: 8] = inv_sbox(s[127-8*(r+4*c) -: 8]);
        end else begin
          o[127-8*(r+4*c) -: 8] = fwd_sbox(s[127-8*m -: 8]);
        end
      end
    end
    return o;
  endfunction

  function automatic logic [127:0] mix_cols(input logic [127:0] s, input logic inv);
    logic [127:0] o;
    logic [7:0] a, b, d2, d3, e, u, v;
    o = s;
    for (int c = 0; c < 4; c++) begin
      a  = s[127-32*c -: 8];
      b  = s[119-32*c -: 8];
      d2 = s[111-32*c -: 8];
      d3 = s[103-32*c -: 8];
      if (inv) begin
        u = xtime(xtime(a ^ d2));
        v = xtime(xtime(b ^ d3));
        a = a ^ u; b = b ^ v; d2 = d2 ^ u; d3 = d3 ^ v;
      end
      e = a ^ b ^ d2 ^ d3;
      o[127-32*c -: 8] = a ^ e ^ xtime(a ^ b);
      o[119-32*c -: 8] = b ^ e ^ xtime(b ^ d2);
      o[111-32*c -: 8] = d2 ^ e ^ xtime(d2 ^ d3);
      o[103-32*c -: 8] = d3 ^ e ^ xtime(d3 ^ a);
    end
    return o;
  endfunction

endpackage

[rtl/aes128_block_cipher_top.sv]
// AES-128 ECB encrypt/decrypt, one block per transfer.
// Each block is loaded, combined with the 11 round-key rows read in turn and
// output; key expansion runs first after reset or a key write. A new block is
// taken only once the last has reached the output register. Round keys are read
// one row per cycle from the round-key memory (128-bit rows, 11 rows). Reset
// clears control and keys; the round keys are rebuilt before the first block.
module aes128_block_cipher_top
  import aes128_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  aes_in_t            in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output aes_out_t           out_data,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [63:0]        cfg_data
);

  // Round-key memory: 11 rows of four words; written during expansion.
  logic [127:0] rk_mem [11];
  logic [127:0] rk_rd;
  logic [3:0]   rk_raddr;
  logic         rk_we;
  logic [3:0]   rk_waddr;
  logic [127:0] rk_wdata;

  logic [63:0]  key_high, key_low;
  logic         key_stale;
  aes_state_t   state, state_next;
  logic [3:0]   cnt, cnt_next;
  logic [127:0] exp_row;
  logic [7:0]   rcon;
  logic         dec;
  logic [127:0] blk;
  logic [127:0] blk_next;
  logic [127:0] res;
  logic         res_valid;

  always_ff @(posedge clk) begin
    if (rk_we) begin
      rk_mem[rk_waddr] <= rk_wdata;
    end
    rk_rd <= rk_mem[rk_raddr];
  end

  // Key expansion: row 0 is the key itself, then one row (four words) per
  // cycle from the previous row.
  logic [31:0] tw;
  always_comb begin
    tw = {fwd_sbox(exp_row[23:16]), fwd_sbox(exp_row[15:8]),
          fwd_sbox(exp_row[7:0]), fwd_sbox(exp_row[31:24])} ^ {rcon, 24'h0};
    rk_wdata[127:96] = exp_row[127:96] ^ tw;
    rk_wdata[95:64]  = exp_row[95:64] ^ rk_wdata[127:96];
    rk_wdata[63:32]  = exp_row[63:32] ^ rk_wdata[95:64];
    rk_wdata[31:0]   = exp_row[31:0] ^ rk_wdata[63:32];
    if (cnt == 4'd0) begin
      rk_wdata = {key_high, key_low};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high  <= '0;
      key_low   <= '0;
      key_stale <= 1'b1;
    end else if (cfg_we) begin
      key_stale <= 1'b1;
      case (cfg_index)
        REG_KEY_HIGH: key_high <= cfg_data;
        REG_KEY_LOW:  key_low  <= cfg_data;
        default:      key_stale <= 1'b1;
      endcase
    end else if (state == ST_EXPAND && cnt == 4'd10) begin
      key_stale <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = key_stale ? ST_EXPAND : ST_LOAD;
          cnt_next   = '0;
        end
      end
      ST_EXPAND: begin
        cnt_next = cnt + 4'd1;
        if (cnt == 4'd10) begin
          state_next = ST_LOAD;
          cnt_next   = '0;
        end
      end
      ST_LOAD: begin
        state_next = ST_ROUND;
        cnt_next   = 4'd1;
      end
      ST_ROUND: begin
        cnt_next = cnt + 4'd1;
        if (cnt == 4'd11) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!res_valid || !out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    rk_we    = (state == ST_EXPAND);
    rk_waddr = cnt;
    in_stall = !(state == ST_IDLE);
    // round counter r = cnt-1 uses row r (encrypt) or 10-r (decrypt); the address runs one row ahead
    if (state == ST_LOAD) begin
      rk_raddr = dec ? 4'd10 : 4'd0;
    end else begin
      rk_raddr = dec ? 4'd10 - cnt : cnt;
    end
    case (cnt)
      4'd1: rcon = 8'h01;  4'd2: rcon = 8'h02;  4'd3: rcon = 8'h04;
      4'd4: rcon = 8'h08;  4'd5: rcon = 8'h10;  4'd6: rcon = 8'h20;
      4'd7: rcon = 8'h40;  4'd8: rcon = 8'h80;  4'd9: rcon = 8'h1b;
      4'd10: rcon = 8'h36;
      default: rcon = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_EXPAND) begin
      exp_row <= (cnt == 4'd0) ? {key_high, key_low} : rk_wdata;
    end
  end

  // Datapath: rk_rd holds the row addressed last cycle.
  logic [127:0] ss;
  always_comb begin
    ss = sub_shift(blk, dec);
    blk_next = blk;
    if (state == ST_ROUND) begin
      if (cnt == 4'd1) begin
        blk_next = blk ^ rk_rd;
      end else if (!dec) begin
        blk_next = (cnt == 4'd11) ? (ss ^ rk_rd) : (mix_cols(ss, 1'b0) ^ rk_rd);
      end else begin
        blk_next = (cnt == 4'd11) ? (ss ^ rk_rd) : mix_cols(ss ^ rk_rd, 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      dec <= in_data.req_type;
      blk <= {in_data.block_high, in_data.block_low};
    end else begin
      blk <= blk_next;
    end
  end

  // Output register: hold the result until the transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == ST_DONE && (!res_valid || !out_stall)) begin
      res_valid <= 1'b1;
      res       <= blk;
    end else if (res_valid && !out_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  assign out_valid           = res_valid;
  assign out_data.result_high = res[127:64];
  assign out_data.result_low  = res[63:0];

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> in_stall) else $error("input taken while busy");
  a_expand_fresh: assert property (@(posedge clk) disable iff (rst)
    state == ST_LOAD && !$past(cfg_we) |-> !key_stale) else $error("stale keys used");
  a_round_cnt: assert property (@(posedge clk) disable iff (rst)
    state == ST_ROUND |-> cnt >= 4'd1 && cnt <= 4'd11) else $error("round count");
  a_done_next: assert property (@(posedge clk) disable iff (rst)
    state == ST_ROUND && cnt == 4'd11 |=> state == ST_DONE) else $error("no done");

endmodule
